// ----- rtl/assert_macros.svh -----
// Assertion macros of the RC5x frame encoder, used by rc5x_ir_frame_encoder.
// Each use is clocked on a named clock and is off while the named reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define RC5X_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition at one edge implies a consequence at the next edge.
`define RC5X_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/rc5x_pkg.sv -----
// Package of the RC5x frame encoder: frame and slot constants, types, register map.
// Used by rc5x_slot_map and rc5x_ir_frame_encoder.
`default_nettype none

package rc5x_pkg;

  localparam int unsigned FRAME_BITS  = 20;
  localparam int unsigned SLOT_COUNT  = 44;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned PAUSE_FIRST = 16;
  localparam int unsigned PAUSE_LAST  = 19;
  localparam int unsigned EXT_FIRST   = 20;
  localparam int unsigned LAST_SLOT   = SLOT_COUNT - 1;

  localparam int unsigned DUR_W       = 16;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic [DUR_W-1:0] HALF_BIT_RESET = 16'd889;

  // Register index taken from the word address bit of paddr
  typedef enum logic [0:0] {
    REG_HALF_BIT = 1'b0,
    REG_NONE     = 1'b1
  } reg_idx_e;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [SLOT_W-1:0]     slot_t;

  typedef struct packed {
    logic level;
    logic last;
  } slot_info_t;

endpackage

`default_nettype wire

// ----- rtl/rc5x_slot_map.sv -----
// Slot mapper of the RC5x frame encoder: level and end-of-frame flag of one slot.
// Depends on rc5x_pkg.
`default_nettype none

module rc5x_slot_map import rc5x_pkg::*; (
  input  frame_t     frame_i,
  input  slot_t      slot_i,
  output slot_info_t info_o
);

  logic             in_pause;
  slot_t            ext_off;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] bit_idx;
  logic             frame_bit;

  always_comb begin
    in_pause = slot_i inside {[SLOT_W'(PAUSE_FIRST):SLOT_W'(PAUSE_LAST)]};
    ext_off  = slot_i - SLOT_W'(EXT_FIRST);
    if (slot_i < SLOT_W'(PAUSE_FIRST)) begin
      pos = slot_i[POS_W:1];
    end else begin
      pos = POS_W'(PAUSE_FIRST / 2) + ext_off[POS_W:1];
    end
    // Send the frame most significant bit first
    bit_idx   = POS_W'(FRAME_BITS - 1) - pos;
    frame_bit = frame_i[bit_idx];
    // A one is space then mark, a zero mark then space
    info_o.level = in_pause ? 1'b0 : ~(frame_bit ^ slot_i[0]);
    info_o.last  = (slot_i == SLOT_W'(LAST_SLOT));
  end

endmodule

`default_nettype wire

// ----- rtl/rc5x_ir_frame_encoder.sv -----
// RC5x infrared frame encoder, top level: stream ports, APB register, slot sequencer.
// Depends on rc5x_pkg, rc5x_slot_map and assert_macros.svh.
//
// Use:
//  - Slave stream: one item per frame request (address, command, extension).
//  - Master stream: 44 items per frame, one half-bit slot each, carrying the
//    level (1 = mark) and the slot length in microseconds; tlast marks the
//    44th slot of the frame.
//  - APB: one register, half_bit_time_us at byte address 0 (reset 889);
//    write it only while the encoder is idle.
//  - Start: a taken request is registered, then its first slot enters the output
//    register; after that, one slot per cycle while the receiver does not stall.
//  - The slot counter walks the 44 slots of a frame; the next request is taken
//    in the cycle the last slot of the current frame enters the output
//    register, so frames run back to back.
//  - The toggle bit is sampled when a request is taken and then flips.
//  - Reset clears the toggle, the sequencer and the output valid, and loads
//    the default slot length.
//  - A receiver stall holds the output register and freezes the slot counter;
//    no slot is dropped or repeated.
`default_nettype none
`include "assert_macros.svh"

module rc5x_ir_frame_encoder import rc5x_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Slave stream
  input  wire logic                  s_tvalid_i,
  output      logic                  s_tready_o,
  input  wire logic [23:0]           s_tdata_i,   // address[4:0], command[11:5], extension[17:12]
  // Master stream
  output      logic                  m_tvalid_o,
  input  wire logic                  m_tready_i,
  output      logic [23:0]           m_tdata_o,   // level[0], duration_us[16:1]
  output      logic                  m_tlast_o,
  // APB register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready
);

  // Configuration register
  logic [DUR_W-1:0] half_bit_q, half_bit_d;
  reg_idx_e         reg_idx;
  logic             cfg_wr;

  // Sequencer state
  logic       busy_q, busy_d;
  slot_t      slot_q, slot_d;
  logic       toggle_q, toggle_d;
  frame_t     frame_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic             level_q;
  logic [DUR_W-1:0] dur_q;
  logic             last_q;

  logic       in_accept;
  logic       advance;
  slot_info_t slot_info;

  logic [4:0] in_address;
  logic [6:0] in_command;
  logic [5:0] in_extension;

  assign in_address   = s_tdata_i[4:0];
  assign in_command   = s_tdata_i[11:5];
  assign in_extension = s_tdata_i[17:12];

  // APB: always ready, word index from paddr[2]
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    half_bit_d = half_bit_q;
    if (cfg_wr && (reg_idx == REG_HALF_BIT)) begin
      half_bit_d = pwdata[DUR_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HALF_BIT: prdata = {{(APB_DATA_W-DUR_W){1'b0}}, half_bit_q};
      default:      prdata = '0;
    endcase
  end

  rc5x_slot_map u_slot_map (
    .frame_i (frame_q),
    .slot_i  (slot_q),
    .info_o  (slot_info)
  );

  // Advance when a slot is pending and the output register is free or draining
  assign advance    = busy_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !busy_q || (advance && slot_info.last);
  assign in_accept  = s_tvalid_i && s_tready_o;

  always_comb begin
    busy_d      = busy_q;
    slot_d      = slot_q;
    toggle_d    = toggle_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
      slot_d      = slot_q + SLOT_W'(1);
      if (slot_info.last) begin
        busy_d = 1'b0;
      end
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    // A new request restarts the sequencer and flips the toggle
    if (in_accept) begin
      busy_d   = 1'b1;
      slot_d   = '0;
      toggle_d = ~toggle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q  <= HALF_BIT_RESET;
      busy_q      <= 1'b0;
      slot_q      <= '0;
      toggle_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      half_bit_q  <= half_bit_d;
      busy_q      <= busy_d;
      slot_q      <= slot_d;
      toggle_q    <= toggle_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      // start, inverted command bit 6, toggle, address, command[5:0], extension
      frame_q <= {1'b1, ~in_command[6], toggle_q, in_address,
                  in_command[5:0], in_extension};
    end
    if (advance) begin
      level_q <= slot_info.level;
      dur_q   <= half_bit_q;
      last_q  <= slot_info.last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(24-DUR_W-1){1'b0}}, dur_q, level_q};
  assign m_tlast_o  = last_q;

  // Checks
  `RC5X_ASSERT(a_accept_at_end, clk_i, rst_ni, (in_accept && busy_q) |-> (slot_q == SLOT_W'(LAST_SLOT)), "request taken mid-frame")
  `RC5X_ASSERT_NEXT(a_toggle_flips, clk_i, rst_ni, in_accept, (toggle_q != $past(toggle_q)), "toggle did not flip")
  `RC5X_ASSERT(a_pause_space, clk_i, rst_ni, (busy_q && (slot_q >= SLOT_W'(PAUSE_FIRST)) && (slot_q <= SLOT_W'(PAUSE_LAST))) |-> !slot_info.level, "pause slot not a space")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking bench for rc5x_ir_frame_encoder: random frame requests in, half-bit slots out.
// Depends on rc5x_pkg and the encoder RTL; it predicts every slot from its own
// frame builder and checks the slots in order.
`default_nettype none

module testbench;
  import rc5x_pkg::*;

  // One frame request as it sits on the slave stream
  typedef struct {
    logic [4:0] address;
    logic [6:0] command;
    logic [5:0] extension;
  } frame_req_t;

  // One half-bit slot as expected on the master stream
  typedef struct {
    logic             level;
    logic [DUR_W-1:0] duration_us;
    logic             last;
  } ir_slot_t;

  // Receiver behaviour: always ready, sparse random stalls, or long on/off stretches
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_SPARSE,
    RX_CHOPPY
  } rx_mode_e;

  localparam int unsigned PAUSE_AT_BIT = 8;
  localparam int unsigned PAUSE_SLOTS  = 4;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [23:0]           s_tdata_i  = '0;   // address[4:0], command[11:5], extension[17:12]
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [23:0]           m_tdata_o;         // level[0], duration_us[16:1]
  logic                  m_tlast_o;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [APB_ADDR_W-1:0] paddr      = '0;
  logic [APB_DATA_W-1:0] pwdata     = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Requests waiting for the driver, slots waiting for the receiver
  frame_req_t       request_q[$];
  ir_slot_t         slot_q[$];

  // Bench copy of the encoder's register and toggle
  logic [DUR_W-1:0] half_bit_us = HALF_BIT_RESET;
  logic             toggle_bit  = 1'b0;

  int unsigned      fail_count    = 0;
  int unsigned      frames_taken  = 0;
  int unsigned      slots_checked = 0;
  int unsigned      reg_writes    = 0;

  always #5 clk_i = ~clk_i;

  rc5x_ir_frame_encoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Build the 44 slots of one frame, using the current toggle, then flip it.
  task automatic predict_frame_slots(input logic [4:0] address, input logic [6:0] command,
                                     input logic [5:0] extension);
    frame_t                frame;
    logic [SLOT_COUNT-1:0] levels;
    int unsigned           n;
    logic                  b;
    ir_slot_t              s;
    frame = {1'b1, ~command[6], toggle_bit, address, command[5:0], extension};
    n = 0;
    for (int pos = 0; pos < FRAME_BITS; pos++) begin
      // Quiet gap between the address and the command
      if (pos == PAUSE_AT_BIT) begin
        for (int i = 0; i < PAUSE_SLOTS; i++) begin
          levels[n] = 1'b0;
          n++;
        end
      end
      // Manchester: a one is space then mark, a zero is mark then space
      b = frame[FRAME_BITS-1-pos];
      levels[n]   = ~b;
      levels[n+1] = b;
      n += 2;
    end
    for (int k = 0; k < SLOT_COUNT; k++) begin
      s.level       = levels[k];
      s.duration_us = half_bit_us;
      s.last        = (k == LAST_SLOT);
      slot_q.push_back(s);
    end
    toggle_bit = ~toggle_bit;
  endtask

  // Sender: pop pending requests in bursts, idling after the first request of a burst
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : request_driver
    frame_req_t req;
    if (rst_ni && (!s_tvalid_i || s_tready_o)) begin
      if (gap_left > 0) begin
        s_tvalid_i <= 1'b0;
        gap_left--;
      end else if (request_q.size() > 0) begin
        req = request_q.pop_front();
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= {6'b0, req.extension, req.command, req.address};
        if (burst_left == 0) begin
          // Start a new burst; a quarter of the bursts run with no gap after their first request
          burst_left = $urandom_range(1, 6);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          gap_left = 0;
        end
        burst_left--;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern in a randomly chosen mode that changes during the run
  rx_mode_e    rx_mode    = RX_STREAM;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk_i) begin : slot_receiver
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(40, 400);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_STREAM: begin
        m_tready_i <= 1'b1;
      end
      RX_SPARSE: begin
        m_tready_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (hold_left == 0) begin
          m_tready_i <= ~m_tready_i;
          hold_left  = $urandom_range(1, 12);
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  // Track register writes, predict on every taken request, check every slot taken
  always @(posedge clk_i) begin : slot_check
    ir_slot_t exp_slot;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_BIT) begin
        half_bit_us = pwdata[DUR_W-1:0];
      end
      if (s_tvalid_i && s_tready_o) begin
        predict_frame_slots(s_tdata_i[4:0], s_tdata_i[11:5], s_tdata_i[17:12]);
        frames_taken++;
      end
      if (m_tvalid_o && m_tready_i) begin
        if (slot_q.size() == 0) begin
          $error("unexpected slot: level %0b duration_us %0d last %0b",
                 m_tdata_o[0], m_tdata_o[16:1], m_tlast_o);
          fail_count++;
        end else begin
          exp_slot = slot_q.pop_front();
          if (m_tdata_o[0] !== exp_slot.level) begin
            $error("level: expected %0b, got %0b", exp_slot.level, m_tdata_o[0]);
            fail_count++;
          end
          if (m_tdata_o[16:1] !== exp_slot.duration_us) begin
            $error("duration_us: expected %0d, got %0d", exp_slot.duration_us,
                   m_tdata_o[16:1]);
            fail_count++;
          end
          if (m_tlast_o !== exp_slot.last) begin
            $error("last: expected %0b, got %0b", exp_slot.last, m_tlast_o);
            fail_count++;
          end
          slots_checked++;
        end
      end
    end
  end

  // APB write: setup cycle, then access until pready
  task automatic apb_write(input reg_idx_e idx, input logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // APB read of the slot length register, checked against the bench copy
  task automatic apb_read_check();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_HALF_BIT, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(APB_DATA_W-DUR_W){1'b0}}, half_bit_us}) begin
      $error("prdata: expected %0d, got %0d", half_bit_us, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every request is taken and every slot has come out
  task automatic wait_for_drain();
    while (request_q.size() > 0 || s_tvalid_i || slot_q.size() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic queue_request(input logic [4:0] a, input logic [6:0] c, input logic [5:0] e);
    frame_req_t req;
    req.address   = a;
    req.command   = c;
    req.extension = e;
    request_q.push_back(req);
  endtask

  task automatic run_random_frames(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      queue_request(5'($urandom()), 7'($urandom()), 6'($urandom()));
    end
    wait_for_drain();
  endtask

  initial begin : sequencer
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at the reset slot length: field extremes, both field-bit
    // polarities, alternating bit patterns; consecutive frames cover both toggles
    queue_request(5'd0,  7'd0,   6'd0);
    queue_request(5'd31, 7'd127, 6'd63);
    queue_request(5'd31, 7'd127, 6'd63);
    queue_request(5'd0,  7'd64,  6'd0);
    queue_request(5'd0,  7'd63,  6'd0);
    queue_request(5'd21, 7'd42,  6'd21);
    queue_request(5'd10, 7'd85,  6'd42);
    queue_request(5'd1,  7'd1,   6'd1);
    queue_request(5'd16, 7'd64,  6'd32);
    queue_request(5'd31, 7'd0,   6'd0);
    queue_request(5'd0,  7'd127, 6'd0);
    queue_request(5'd0,  7'd0,   6'd63);
    queue_request(5'd31, 7'd63,  6'd63);
    queue_request(5'd0,  7'd64,  6'd63);
    wait_for_drain();
    apb_read_check();

    // Zero slot length is stored as is; a write to the unused address must not stick
    apb_write(REG_HALF_BIT, {16'($urandom()), 16'd0});
    apb_write(REG_NONE, $urandom());
    apb_read_check();
    run_random_frames(30);

    // Largest slot length, junk in the upper data bits
    apb_write(REG_HALF_BIT, {16'($urandom()), 16'hFFFF});
    apb_read_check();
    run_random_frames(30);

    // Smallest legal slot length
    apb_write(REG_HALF_BIT, 32'd1);
    run_random_frames(30);

    apb_write(REG_HALF_BIT, $urandom());
    apb_write(REG_NONE, $urandom());
    apb_read_check();
    run_random_frames(35);

    // Back to the default length
    apb_write(REG_HALF_BIT, {16'd0, HALF_BIT_RESET});
    apb_read_check();
    run_random_frames(35);

    // Let any stray slot show up before the verdict
    repeat (60) @(negedge clk_i);

    $display("Covered %0d frame requests and %0d half-bit slots over %0d register writes,",
             frames_taken, slots_checked, reg_writes);
    $display("with slot lengths 0, 1, 889, 65535 and random, under random stalls on both sides.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- rc5x_ir_frame_encoder.f -----
+incdir+rtl
rtl/rc5x_pkg.sv
rtl/rc5x_slot_map.sv
rtl/rc5x_ir_frame_encoder.sv
dv/testbench.sv
